[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, off during reset
`define SDF_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sdf check failed");

// same check with a message of its own
`define SDF_CHECK_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

[design/sdf_pkg.sv]
`timescale 1ns / 1ps
package sdf_pkg;

  localparam logic [1:0] KIND_IP  = 2'd0;
  localparam logic [1:0] KIND_ARP = 2'd1;

  localparam logic [2:0] VERDICT_NEW     = 3'd0;
  localparam logic [2:0] VERDICT_APPEND  = 3'd1;
  localparam logic [2:0] VERDICT_DROPPED = 3'd2;
  localparam logic [2:0] VERDICT_IGNORED = 3'd3;
  localparam logic [2:0] VERDICT_UNKNOWN = 3'd4;
  localparam logic [2:0] VERDICT_FULL    = 3'd5;

  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [15:0] FLAG_SYN  = 16'h0002;
  localparam logic [15:0] FLAG_ACK  = 16'h0010;

  localparam logic [1:0] REG_KEEP_ERRORS     = 2'd0;
  localparam logic [1:0] REG_KEEP_DUPS       = 2'd1;
  localparam logic [1:0] REG_IMMEDIATE_PRINT = 2'd2;
  localparam logic [1:0] REG_COMPOUND_MODE   = 2'd3;

  typedef struct packed {
    logic        valid;
    logic        lookup;
    logic        is_arp;
    logic [2:0]  pre_verdict;
    logic        matched;
    logic        stored;
    logic        open;
    logic [63:0] key;
  } sdf_item_t;

endpackage

[design/sdf_if.sv]
`timescale 1ns / 1ps
interface sdf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] target_ip;
  logic [15:0] port;
  logic [31:0] sender_addr;
  logic [7:0]  proto;
  logic [15:0] resp_type;
  logic [47:0] hw_addr;

  modport source (output valid, kind, target_ip, port, sender_addr, proto, resp_type,
                  hw_addr, input ready);
  modport sink (input valid, kind, target_ip, port, sender_addr, proto, resp_type,
                hw_addr, output ready);
endinterface

interface sdf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [63:0] report_key;
  logic        print_now;
  logic        was_open;

  modport source (output valid, verdict, report_key, print_now, was_open, input ready);
  modport sink (input valid, verdict, report_key, print_now, was_open, output ready);
endinterface

[design/scan_report_dedup_filter.sv]
`timescale 1ns / 1ps
// Scan report duplicate filter. Takes one scan response item per cycle while
// the output is not stalled and returns one result item per input item, in
// order. The key of each item walks a chain of TABLE_DEPTH cells, one cell per
// unstalled cycle, and each cell holds one stored key; a new key is written into
// the first free cell it reaches. With the output taken every cycle the block
// sustains one item per cycle. A stalled output freezes the whole chain. Stored
// keys have no reset; the fill count and the duplicate block are cleared.
// Registers must be written only while the block holds no item; the block does
// not enforce this. A write of keep_dups also lifts the duplicate block.
module scan_report_dedup_filter #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  sdf_in_if.sink      in_chan,
  sdf_out_if.source   out_chan,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import sdf_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  logic keep_errors_r;
  logic keep_dups_r;
  logic immediate_print_r;
  logic compound_mode_r;
  logic dups_blocked_r;
  logic [CNT_W-1:0] fill_r;

  logic       cfg_wr;
  logic [1:0] cfg_idx;
  logic       advance;

  sdf_item_t front_nxt;
  sdf_item_t front_r;
  sdf_item_t chain [TABLE_DEPTH+1];
  sdf_item_t tail;
  logic      ins_vec [TABLE_DEPTH];
  logic      fill_inc;

  logic        out_valid_r;
  logic [2:0]  verdict_r;
  logic [63:0] key_r;
  logic        print_now_r;
  logic        was_open_r;
  logic [2:0]  verdict_nxt;
  logic        print_nxt;
  logic        block_set;
  logic        dups_on;
  logic        ip_open;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_KEEP_ERRORS:     cfg_prdata[0] = keep_errors_r;
      REG_KEEP_DUPS:       cfg_prdata[0] = keep_dups_r;
      REG_IMMEDIATE_PRINT: cfg_prdata[0] = immediate_print_r;
      REG_COMPOUND_MODE:   cfg_prdata[0] = compound_mode_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_errors_r     <= 1'b0;
      keep_dups_r       <= 1'b0;
      immediate_print_r <= 1'b0;
      compound_mode_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_KEEP_ERRORS:     keep_errors_r     <= cfg_pwdata[0];
        REG_KEEP_DUPS:       keep_dups_r       <= cfg_pwdata[0];
        REG_IMMEDIATE_PRINT: immediate_print_r <= cfg_pwdata[0];
        REG_COMPOUND_MODE:   compound_mode_r   <= cfg_pwdata[0];
      endcase
    end
  end

  // front end: key and classification
  assign advance       = !out_valid_r || out_chan.ready;
  assign in_chan.ready = advance;

  assign ip_open = ((in_chan.proto == PROTO_TCP) &&
                    ((in_chan.resp_type & (FLAG_SYN | FLAG_ACK)) == (FLAG_SYN | FLAG_ACK))) ||
                   (in_chan.proto == PROTO_UDP);

  always_comb begin
    front_nxt             = '0;
    front_nxt.valid       = in_chan.valid;
    front_nxt.pre_verdict = VERDICT_UNKNOWN;
    if (in_chan.kind == KIND_IP) begin
      front_nxt.key = {in_chan.target_ip, in_chan.port,
                       in_chan.sender_addr[31:16] ^ in_chan.sender_addr[15:0]};
      front_nxt.open        = ip_open;
      front_nxt.lookup      = ip_open || keep_errors_r;
      front_nxt.pre_verdict = VERDICT_IGNORED;
    end else if (in_chan.kind == KIND_ARP) begin
      front_nxt.key = {in_chan.target_ip, in_chan.hw_addr[47:40], in_chan.hw_addr[39:32],
                       in_chan.hw_addr[31:24] ^ in_chan.hw_addr[23:16],
                       in_chan.hw_addr[7:0] ^ in_chan.hw_addr[15:8]};
      front_nxt.lookup = 1'b1;
      front_nxt.is_arp = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.valid <= 1'b0;
    end else if (advance) begin
      front_r <= front_nxt;
    end
  end

  assign chain[0] = front_r;

  // cell chain
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    sdf_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .fill     (fill_r),
      .item_in  (chain[i]),
      .item_out (chain[i+1]),
      .ins      (ins_vec[i])
    );
  end

  assign tail     = chain[TABLE_DEPTH];
  assign fill_inc = advance && (fill_r < CNT_W'(TABLE_DEPTH)) && ins_vec[fill_r[IDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (fill_inc) begin
      fill_r <= fill_r + 1'b1;
    end
  end

  // back end: verdict
  assign dups_on = keep_dups_r && !dups_blocked_r;

  always_comb begin
    verdict_nxt = tail.pre_verdict;
    print_nxt   = 1'b0;
    block_set   = 1'b0;
    if (tail.lookup) begin
      if (tail.stored) begin
        verdict_nxt = VERDICT_NEW;
        print_nxt   = immediate_print_r && !(tail.is_arp && compound_mode_r);
      end else if (tail.matched) begin
        if (!tail.is_arp && dups_on) begin
          verdict_nxt = VERDICT_APPEND;
          print_nxt   = immediate_print_r;
        end else begin
          verdict_nxt = VERDICT_DROPPED;
        end
        block_set = tail.is_arp && dups_on;
      end else begin
        verdict_nxt = VERDICT_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dups_blocked_r <= 1'b0;
    end else if (cfg_wr && (cfg_idx == REG_KEEP_DUPS)) begin
      dups_blocked_r <= 1'b0;
    end else if (advance && tail.valid && block_set) begin
      dups_blocked_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      verdict_r   <= verdict_nxt;
      key_r       <= tail.key;
      print_now_r <= print_nxt;
      was_open_r  <= tail.open;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.verdict    = verdict_r;
  assign out_chan.report_key = key_r;
  assign out_chan.print_now  = print_now_r;
  assign out_chan.was_open   = was_open_r;

  `SDF_CHECK(a_fill_bound, fill_r <= CNT_W'(TABLE_DEPTH))
  `SDF_CHECK(a_stall_needs_result, !in_chan.ready |-> out_valid_r)
  `SDF_CHECK(a_fill_moves, fill_inc |=> fill_r != $past(fill_r))
  `SDF_CHECK_MSG(a_tail_store_or_match, tail.valid |-> !(tail.stored && tail.matched),
    "item both matched and stored")
  `SDF_CHECK_MSG(a_print_only_kept,
    (out_valid_r && print_now_r) |-> (verdict_r == VERDICT_NEW || verdict_r == VERDICT_APPEND),
    "print request on a dropped item")

endmodule

[design/sdf_cell.sv]
`timescale 1ns / 1ps
module sdf_cell #(
  parameter int unsigned CNT_W = 9,
  parameter int unsigned IDX   = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic [CNT_W-1:0]   fill,
  input  sdf_pkg::sdf_item_t item_in,
  output sdf_pkg::sdf_item_t item_out,
  output logic               ins
);
  import sdf_pkg::*;

  sdf_item_t   item_r;
  logic [63:0] key_r;
  logic        occupied;
  logic        next_free;
  logic        hit;

  assign occupied  = CNT_W'(IDX) < fill;
  assign next_free = CNT_W'(IDX) == fill;
  assign hit = item_r.valid && item_r.lookup && occupied && (key_r == item_r.key);
  assign ins = item_r.valid && item_r.lookup && next_free && !item_r.matched &&
               !item_r.stored;

  always_comb begin
    item_out         = item_r;
    item_out.matched = item_r.matched | hit;
    item_out.stored  = item_r.stored | ins;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else if (advance) begin
      item_r <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ins) begin
      key_r <= item_r.key;
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
  import sdf_pkg::*;

  localparam int TABLE_DEPTH = 256;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int FRESH_CAP = 200;
  localparam int HISTORY_DEPTH = 128;
  localparam int PHASE_ITEMS = 90;
  localparam int FULL_PHASE_ITEMS = 40;

  localparam logic [1:0] KIND_SPARE_A = 2'd2;
  localparam logic [1:0] KIND_SPARE_B = 2'd3;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [15:0] FLAGS_OPEN = FLAG_SYN | FLAG_ACK;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] target_ip;
    logic [15:0] port;
    logic [31:0] sender_addr;
    logic [7:0]  proto;
    logic [15:0] resp_type;
    logic [47:0] hw_addr;
  } scan_rsp_t;

  typedef struct {
    logic [2:0]  verdict;
    logic [63:0] report_key;
    logic        print_now;
    logic        was_open;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [3:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  sdf_in_if in_chan ();
  sdf_out_if out_chan ();

  scan_report_dedup_filter #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // predictor state
  logic [63:0] seen_keys [TABLE_DEPTH];
  int table_fill;
  logic dups_blocked;
  logic keep_errors;
  logic keep_dups;
  logic immediate_print;
  logic compound_mode;

  verdict_t pending_verdicts[$];
  scan_rsp_t stored_reports[$];
  verdict_t due;
  int mismatches;
  int unsigned cycle_count;
  int send_gap_pct;
  int recv_stall_pct;
  int send_gap_by_mode[4] = '{0, 66, 0, 22};
  int recv_stall_by_mode[4] = '{0, 0, 66, 22};

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic bit key_seen(logic [63:0] key);
    for (int i = 0; i < table_fill; i++) begin
      if (seen_keys[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic verdict_t classify_report(scan_rsp_t r);
    verdict_t o;
    logic dups_live;
    logic [7:0] b0, b1, b2, b3, b4, b5;
    o = '{VERDICT_UNKNOWN, 64'd0, 1'b0, 1'b0};
    dups_live = keep_dups && !dups_blocked;
    if (r.kind == KIND_IP) begin
      o.report_key = {r.target_ip, r.port, r.sender_addr[31:16] ^ r.sender_addr[15:0]};
      o.was_open = (r.proto == PROTO_UDP) ||
                   (r.proto == PROTO_TCP && (r.resp_type & FLAGS_OPEN) == FLAGS_OPEN);
      if (!o.was_open && !keep_errors) begin
        o.verdict = VERDICT_IGNORED;
      end else if (!key_seen(o.report_key)) begin
        if (table_fill < TABLE_DEPTH) begin
          seen_keys[table_fill] = o.report_key;
          table_fill++;
          o.verdict = VERDICT_NEW;
          o.print_now = immediate_print;
        end else begin
          o.verdict = VERDICT_FULL;
        end
      end else if (dups_live) begin
        o.verdict = VERDICT_APPEND;
        o.print_now = immediate_print;
      end else begin
        o.verdict = VERDICT_DROPPED;
      end
    end else if (r.kind == KIND_ARP) begin
      {b5, b4, b3, b2, b1, b0} = r.hw_addr;
      o.report_key = {r.target_ip, b5, b4, b3 ^ b2, b0 ^ b1};
      if (!key_seen(o.report_key)) begin
        if (table_fill < TABLE_DEPTH) begin
          seen_keys[table_fill] = o.report_key;
          table_fill++;
          o.verdict = VERDICT_NEW;
          o.print_now = immediate_print && !compound_mode;
        end else begin
          o.verdict = VERDICT_FULL;
        end
      end else begin
        if (dups_live) dups_blocked = 1'b1;
        o.verdict = VERDICT_DROPPED;
      end
    end
    return o;
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        $error("result item with none pending, key %0h", out_chan.report_key);
      end else begin
        due = pending_verdicts.pop_front();
        check_field("verdict", 64'(due.verdict), 64'(out_chan.verdict));
        check_field("report_key", due.report_key, out_chan.report_key);
        check_field("print_now", 64'(due.print_now), 64'(out_chan.print_now));
        check_field("was_open", 64'(due.was_open), 64'(out_chan.was_open));
      end
    end
  end

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic scan_rsp_t fresh_report();
    scan_rsp_t r;
    int pick;
    r.kind = ($urandom_range(99) < 60) ? KIND_IP : KIND_ARP;
    r.target_ip = $urandom;
    r.port = 16'($urandom);
    r.sender_addr = $urandom;
    pick = $urandom_range(99);
    r.proto = (pick < 40) ? PROTO_TCP : (pick < 65) ? PROTO_UDP : 8'($urandom);
    r.resp_type = 16'($urandom) | (($urandom_range(1) == 1) ? FLAGS_OPEN : 16'h0000);
    r.hw_addr = {16'($urandom), 32'($urandom)};
    return r;
  endfunction

  // same key, other content
  function automatic scan_rsp_t repeat_of(scan_rsp_t src);
    scan_rsp_t r;
    logic [15:0] hi;
    logic [7:0] nb;
    r = fresh_report();
    r.kind = src.kind;
    r.target_ip = src.target_ip;
    r.port = src.port;
    hi = 16'($urandom);
    r.sender_addr = {hi, hi ^ src.sender_addr[31:16] ^ src.sender_addr[15:0]};
    r.hw_addr[47:32] = src.hw_addr[47:32];
    nb = 8'($urandom);
    r.hw_addr[23:16] = nb;
    r.hw_addr[31:24] = nb ^ src.hw_addr[31:24] ^ src.hw_addr[23:16];
    nb = 8'($urandom);
    r.hw_addr[15:8] = nb;
    r.hw_addr[7:0] = nb ^ src.hw_addr[7:0] ^ src.hw_addr[15:8];
    return r;
  endfunction

  function automatic scan_rsp_t random_report(bit allow_fresh);
    scan_rsp_t r;
    int pick;
    pick = $urandom_range(99);
    r = fresh_report();
    if (pick < 5) begin
      r.kind = pick[0] ? KIND_SPARE_A : KIND_SPARE_B;
    end else if (stored_reports.size() != 0 && (pick < 80 || !allow_fresh)) begin
      r = repeat_of(stored_reports[$urandom_range(stored_reports.size() - 1)]);
    end
    return r;
  endfunction

  task automatic send_report(input scan_rsp_t r);
    verdict_t o;
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.kind = r.kind;
    in_chan.target_ip = r.target_ip;
    in_chan.port = r.port;
    in_chan.sender_addr = r.sender_addr;
    in_chan.proto = r.proto;
    in_chan.resp_type = r.resp_type;
    in_chan.hw_addr = r.hw_addr;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    o = classify_report(r);
    pending_verdicts.push_back(o);
    if (o.verdict == VERDICT_NEW) begin
      stored_reports.push_back(r);
      if (stored_reports.size() > HISTORY_DEPTH) void'(stored_reports.pop_front());
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic value);
    wait_drained();
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = {31'd0, value};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    case (idx)
      REG_KEEP_ERRORS: keep_errors = value;
      REG_KEEP_DUPS: begin
        keep_dups = value;
        dups_blocked = 1'b0;
      end
      REG_IMMEDIATE_PRINT: immediate_print = value;
      REG_COMPOUND_MODE: compound_mode = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  // bit 0 keep_errors, 1 keep_dups, 2 immediate_print, 3 compound_mode
  task automatic apply_settings(input logic [3:0] setting, input int idle_mode);
    write_reg(REG_KEEP_ERRORS, setting[0]);
    write_reg(REG_KEEP_DUPS, setting[1]);
    write_reg(REG_IMMEDIATE_PRINT, setting[2]);
    write_reg(REG_COMPOUND_MODE, setting[3]);
    send_gap_pct = send_gap_by_mode[idle_mode];
    recv_stall_pct = recv_stall_by_mode[idle_mode];
  endtask

  task automatic run_random_phase(input int items, input bit capped);
    for (int i = 0; i < items; i++) begin
      if (i == items / 2 || $urandom_range(199) == 0) wait_drained();
      send_report(random_report(!capped || table_fill < FRESH_CAP));
    end
  endtask

  task automatic test_directed();
    scan_rsp_t ip_open;
    scan_rsp_t arp_first;
    scan_rsp_t probe;
    apply_settings(4'b0000, 0);
    send_report('{KIND_SPARE_B, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF,
                  48'hFFFF_FFFF_FFFF});
    send_report('{KIND_SPARE_A, 32'h0, 16'h0, 32'h0, 8'h0, 16'h0, 48'h0});
    // closed and error replies without error keeping
    send_report('{KIND_IP, 32'h0A00_0001, 16'd80, 32'hC0A8_0001, PROTO_TCP, FLAG_SYN, 48'h0});
    send_report('{KIND_IP, 32'h0A00_0001, 16'd81, 32'hC0A8_0001, PROTO_TCP, FLAG_ACK, 48'h0});
    ip_open = '{KIND_IP, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, PROTO_TCP, 16'hFFFF,
                48'hFFFF_FFFF_FFFF};
    send_report(ip_open);
    write_reg(REG_KEEP_DUPS, 1'b1);
    write_reg(REG_IMMEDIATE_PRINT, 1'b1);
    send_report(ip_open);
    send_report('{KIND_IP, 32'h0, 16'h0, 32'h0, PROTO_UDP, 16'h0, 48'h0});
    probe = '{KIND_IP, 32'h0A00_0002, 16'd443, 32'h1234_5678, PROTO_ICMP, 16'd3, 48'h0};
    send_report(probe);
    write_reg(REG_KEEP_ERRORS, 1'b1);
    send_report(probe);
    arp_first = '{KIND_ARP, 32'h0, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF,
                  48'hFFFF_FFFF_FFFF};
    send_report(arp_first);
    write_reg(REG_COMPOUND_MODE, 1'b1);
    send_report('{KIND_ARP, 32'hFFFF_FFFF, 16'h0, 32'h0, 8'h0, 16'h0, 48'h0});
    // arp repeat blocks duplicate keeping until keep_dups is written
    send_report(repeat_of(arp_first));
    send_report(ip_open);
    write_reg(REG_KEEP_DUPS, 1'b1);
    send_report(ip_open);
    write_reg(REG_KEEP_DUPS, 1'b0);
    send_report(ip_open);
    wait_drained();
  endtask

  task automatic test_random_settings();
    for (int s = 0; s < 16; s++) begin
      apply_settings(4'(s), (s + s / 4) % 4);
      run_random_phase(PHASE_ITEMS, 1'b1);
    end
    wait_drained();
  endtask

  task automatic test_table_full();
    scan_rsp_t r;
    logic [3:0] full_settings[4] = '{4'b1111, 4'b0000, 4'b0101, 4'b1010};
    apply_settings(4'b0111, 0);
    while (table_fill < TABLE_DEPTH) begin
      r = fresh_report();
      r.kind = KIND_ARP;
      send_report(r);
    end
    r = fresh_report();
    r.kind = KIND_ARP;
    send_report(r);
    r = fresh_report();
    r.kind = KIND_IP;
    r.proto = PROTO_UDP;
    send_report(r);
    send_report(repeat_of(stored_reports[0]));
    send_report(repeat_of(stored_reports[stored_reports.size() - 1]));
    for (int p = 0; p < 4; p++) begin
      apply_settings(full_settings[p], p);
      run_random_phase(FULL_PHASE_ITEMS, 1'b0);
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_chan.valid = 1'b0;
    in_chan.kind = KIND_IP;
    in_chan.target_ip = '0;
    in_chan.port = '0;
    in_chan.sender_addr = '0;
    in_chan.proto = '0;
    in_chan.resp_type = '0;
    in_chan.hw_addr = '0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    cycle_count = 0;
    table_fill = 0;
    dups_blocked = 1'b0;
    keep_errors = 1'b0;
    keep_dups = 1'b0;
    immediate_print = 1'b0;
    compound_mode = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_settings();
    test_table_full();
    wait_drained();
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+design
design/sdf_pkg.sv
design/sdf_if.sv
design/sdf_cell.sv
design/scan_report_dedup_filter.sv
tb/tb.sv
